@@ hw/rtl/sipt_pkg.sv @@
// ============================================================================
// sipt_pkg: shared constants and types for the segment intersection block
// Default widths, register indexes and the flag group that rides the
// divider pipeline next to the data.
// ============================================================================
package sipt_pkg;

   // Default widths
   localparam int SIPT_COORD_BITS = 16;
   localparam int SIPT_FRAC_BITS  = 16;

   // Register file
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_START_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_START_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_END_X   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_END_Y   = 2'd3;

   // Per-beat flags carried alongside the divider lanes
   typedef struct packed {
      logic hit;    // segments cross strictly inside both
      logic neg_x;  // B.x - A.x is negative
      logic neg_y;  // B.y - A.y is negative
   } sipt_flags_type;

endpackage

@@ hw/rtl/sipt_ifs.sv @@
// ============================================================================
// sipt_ifs: valid/ready channels of the segment intersection block
// Query channel (segment A->B) and result channel (hit, point, fraction).
// ============================================================================
interface sipt_req_if #(
   parameter int COORD_BITS = sipt_pkg::SIPT_COORD_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] query_start_x;
   logic signed [COORD_BITS-1:0] query_start_y;
   logic signed [COORD_BITS-1:0] query_end_x;
   logic signed [COORD_BITS-1:0] query_end_y;

   modport source (
      output valid, query_start_x, query_start_y, query_end_x, query_end_y,
      input  ready
   );
   modport sink (
      input  valid, query_start_x, query_start_y, query_end_x, query_end_y,
      output ready
   );
endinterface

interface sipt_rsp_if #(
   parameter int COORD_BITS = sipt_pkg::SIPT_COORD_BITS,
   parameter int FRAC_BITS  = sipt_pkg::SIPT_FRAC_BITS
);
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic signed [COORD_BITS-1:0] hit_x;
   logic signed [COORD_BITS-1:0] hit_y;
   logic        [FRAC_BITS:0]    fraction;

   modport source (
      output valid, hit, hit_x, hit_y, fraction,
      input  ready
   );
   modport sink (
      input  valid, hit, hit_x, hit_y, fraction,
      output ready
   );
endinterface

@@ hw/rtl/sipt_mdiv.sv @@
// ============================================================================
// sipt_mdiv: pipelined scaled divider, three lanes
// Each lane forms floor(num * m / den) for num < den, one bit of m per
// stage, MSB first. Lanes: m = |dx|, m = |dy|, m = 2^FRAC_BITS.
// ============================================================================
module sipt_mdiv #(
   parameter int COORD_BITS = sipt_pkg::SIPT_COORD_BITS,
   parameter int FRAC_BITS  = sipt_pkg::SIPT_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   // upstream
   input  logic                            in_valid,
   output logic                            in_ready,
   input  sipt_pkg::sipt_flags_type        in_flags,
   input  logic signed [COORD_BITS-1:0]    in_ax,
   input  logic signed [COORD_BITS-1:0]    in_ay,
   input  logic [2*COORD_BITS:0]           in_num,
   input  logic [2*COORD_BITS:0]           in_den,
   input  logic [((COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS+1)-1:0] in_mul_x,
   input  logic [((COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS+1)-1:0] in_mul_y,
   // downstream
   output logic                            out_valid,
   input  logic                            out_ready,
   output sipt_pkg::sipt_flags_type        out_flags,
   output logic signed [COORD_BITS-1:0]    out_ax,
   output logic signed [COORD_BITS-1:0]    out_ay,
   output logic [((COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS+1)-1:0] out_quo_x,
   output logic [((COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS+1)-1:0] out_quo_y,
   output logic [((COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS+1)-1:0] out_quo_f
);

   localparam int MW = 2*COORD_BITS + 1;                       // magnitude width
   localparam int MQ = (COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS + 1;
   localparam int TW = MW + 2;                                 // 2*rem + num
   localparam logic [MQ-1:0] MUL_F = MQ'(1) << FRAC_BITS;

   // One step: q,rem <- 2q + k, 2rem + bit*num - k*den, k in {0,1,2}
   function automatic logic [MQ+MW-1:0] div_step(
      input logic [MW-1:0] rem,
      input logic [MQ-1:0] quo,
      input logic [MW-1:0] num,
      input logic [MW-1:0] den,
      input logic          mbit
   );
      logic [TW-1:0] t;
      logic [TW-1:0] d1;
      logic [TW-1:0] d2;
      logic [MQ-1:0] qn;
      logic [MW-1:0] rn;
      t  = {1'b0, rem, 1'b0} + (mbit ? {2'b00, num} : {TW{1'b0}});
      d1 = {2'b00, den};
      d2 = {1'b0, den, 1'b0};
      priority if (t >= d2) begin
         rn = MW'(t - d2);
         qn = {quo[MQ-2:0], 1'b0} + MQ'(2);
      end else if (t >= d1) begin
         rn = MW'(t - d1);
         qn = {quo[MQ-2:0], 1'b1};
      end else begin
         rn = MW'(t);
         qn = {quo[MQ-2:0], 1'b0};
      end
      return {qn, rn};
   endfunction

   // Stage registers
   logic                     valid_ff [MQ];
   sipt_pkg::sipt_flags_type flags_ff [MQ];
   logic signed [COORD_BITS-1:0] ax_ff [MQ];
   logic signed [COORD_BITS-1:0] ay_ff [MQ];
   logic [MW-1:0] num_ff  [MQ];
   logic [MW-1:0] den_ff  [MQ];
   logic [MQ-1:0] mx_ff   [MQ];
   logic [MQ-1:0] my_ff   [MQ];
   logic [MW-1:0] remx_ff [MQ];
   logic [MW-1:0] remy_ff [MQ];
   logic [MW-1:0] remf_ff [MQ];
   logic [MQ-1:0] qx_ff   [MQ];
   logic [MQ-1:0] qy_ff   [MQ];
   logic [MQ-1:0] qf_ff   [MQ];

   // Stage load enables; rdy[j] = stage j may take a beat
   logic rdy [MQ+1];
   assign rdy[MQ]  = out_ready;
   assign in_ready = rdy[0];

   genvar j;
   for (j = 0; j < MQ; j++) begin : g_stage
      logic                     src_valid;
      sipt_pkg::sipt_flags_type src_flags;
      logic signed [COORD_BITS-1:0] src_ax;
      logic signed [COORD_BITS-1:0] src_ay;
      logic [MW-1:0] src_num;
      logic [MW-1:0] src_den;
      logic [MQ-1:0] src_mx;
      logic [MQ-1:0] src_my;
      logic [MW-1:0] src_remx;
      logic [MW-1:0] src_remy;
      logic [MW-1:0] src_remf;
      logic [MQ-1:0] src_qx;
      logic [MQ-1:0] src_qy;
      logic [MQ-1:0] src_qf;
      logic [MQ+MW-1:0] step_x;
      logic [MQ+MW-1:0] step_y;
      logic [MQ+MW-1:0] step_f;

      // Source: ports for the first stage, previous stage otherwise
      if (j == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_flags = in_flags;
         assign src_ax    = in_ax;
         assign src_ay    = in_ay;
         assign src_num   = in_num;
         assign src_den   = in_den;
         assign src_mx    = in_mul_x;
         assign src_my    = in_mul_y;
         assign src_remx  = '0;
         assign src_remy  = '0;
         assign src_remf  = '0;
         assign src_qx    = '0;
         assign src_qy    = '0;
         assign src_qf    = '0;
      end else begin : g_next
         assign src_valid = valid_ff[j-1];
         assign src_flags = flags_ff[j-1];
         assign src_ax    = ax_ff[j-1];
         assign src_ay    = ay_ff[j-1];
         assign src_num   = num_ff[j-1];
         assign src_den   = den_ff[j-1];
         assign src_mx    = mx_ff[j-1];
         assign src_my    = my_ff[j-1];
         assign src_remx  = remx_ff[j-1];
         assign src_remy  = remy_ff[j-1];
         assign src_remf  = remf_ff[j-1];
         assign src_qx    = qx_ff[j-1];
         assign src_qy    = qy_ff[j-1];
         assign src_qf    = qf_ff[j-1];
      end

      // Bit MQ-1-j of each lane's multiplier
      assign step_x = div_step(src_remx, src_qx, src_num, src_den, src_mx[MQ-1-j]);
      assign step_y = div_step(src_remy, src_qy, src_num, src_den, src_my[MQ-1-j]);
      assign step_f = div_step(src_remf, src_qf, src_num, src_den, MUL_F[MQ-1-j]);

      assign rdy[j] = !valid_ff[j] || rdy[j+1];

      // Valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            valid_ff[j] <= src_valid;
         end
      end

      // Payload
      always_ff @(posedge clock) begin
         if (rdy[j]) begin
            flags_ff[j] <= src_flags;
            ax_ff[j]    <= src_ax;
            ay_ff[j]    <= src_ay;
            num_ff[j]   <= src_num;
            den_ff[j]   <= src_den;
            mx_ff[j]    <= src_mx;
            my_ff[j]    <= src_my;
            qx_ff[j]    <= step_x[MQ+MW-1:MW];
            remx_ff[j]  <= step_x[MW-1:0];
            qy_ff[j]    <= step_y[MQ+MW-1:MW];
            remy_ff[j]  <= step_y[MW-1:0];
            qf_ff[j]    <= step_f[MQ+MW-1:MW];
            remf_ff[j]  <= step_f[MW-1:0];
         end
      end
   end

   assign out_valid = valid_ff[MQ-1];
   assign out_flags = flags_ff[MQ-1];
   assign out_ax    = ax_ff[MQ-1];
   assign out_ay    = ay_ff[MQ-1];
   assign out_quo_x = qx_ff[MQ-1];
   assign out_quo_y = qy_ff[MQ-1];
   assign out_quo_f = qf_ff[MQ-1];

endmodule

@@ hw/rtl/segment_intersection_point_top.sv @@
// ============================================================================
// segment_intersection_point_top: query segment vs. stored segment test
// Exact cross-product test of A->B against C->D; reports hit, the
// fraction S along A->B in Q1.FRAC_BITS and the crossing point.
// ============================================================================
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  req_bus | in  | valid/ready        | query_start_x/y, query_end_x/y
//  rsp_bus | out | valid/ready        | hit, hit_x, hit_y, fraction
//  csr_*   | in  | csr_write_en       | csr_index, csr_data (C.x C.y D.x D.y)
//
//  One beat per cycle in and out while the output is not stalled. The
//  divider resolves one quotient bit per stage. Every stage has its own
//  valid bit; a stalled output only backs up as far as the first empty
//  stage.
//  Reset (synchronous) clears all valid bits and loads C=(0,0), D=(1,1).
//
module segment_intersection_point_top #(
   parameter int COORD_BITS = sipt_pkg::SIPT_COORD_BITS,
   parameter int FRAC_BITS  = sipt_pkg::SIPT_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   sipt_req_if.sink                              req_bus,
   sipt_rsp_if.source                            rsp_bus,
   input  logic                                  csr_write_en,
   input  logic [sipt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [COORD_BITS-1:0]                 csr_data
);

   localparam int W  = COORD_BITS;
   localparam int DW = W + 1;          // coordinate difference
   localparam int PW = 2*W + 2;        // signed cross product
   localparam int MW = 2*W + 1;        // cross product magnitude
   localparam int MQ = (COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS + 1;

   // ---------------------------------------------------------------------
   // Stored segment registers
   // ---------------------------------------------------------------------
   logic signed [W-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         end_x_ff   <= W'(1);
         end_y_ff   <= W'(1);
      end else if (csr_write_en) begin
         unique case (csr_index)
            sipt_pkg::CSR_LINE_START_X: start_x_ff <= csr_data;
            sipt_pkg::CSR_LINE_START_Y: start_y_ff <= csr_data;
            sipt_pkg::CSR_LINE_END_X:   end_x_ff   <= csr_data;
            sipt_pkg::CSR_LINE_END_Y:   end_y_ff   <= csr_data;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage load enables, output back to input
   // ---------------------------------------------------------------------
   logic p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff, out_v_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
   logic div_in_ready;
   logic div_out_valid;

   assign rdy_out       = !out_v_ff || rsp_bus.ready;
   assign rdy5          = !p5_v_ff || div_in_ready;
   assign rdy4          = !p4_v_ff || rdy5;
   assign rdy3          = !p3_v_ff || rdy4;
   assign rdy2          = !p2_v_ff || rdy3;
   assign rdy1          = !p1_v_ff || rdy2;
   assign req_bus.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         p3_v_ff  <= 1'b0;
         p4_v_ff  <= 1'b0;
         p5_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy1)    p1_v_ff  <= req_bus.valid;
         if (rdy2)    p2_v_ff  <= p1_v_ff;
         if (rdy3)    p3_v_ff  <= p2_v_ff;
         if (rdy4)    p4_v_ff  <= p3_v_ff;
         if (rdy5)    p5_v_ff  <= p4_v_ff;
         if (rdy_out) out_v_ff <= div_out_valid;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: directions r = B-A, s = D-C and offset q = C-A
   // ---------------------------------------------------------------------
   logic signed [DW-1:0] p1_rx_in, p1_ry_in, p1_sx_in, p1_sy_in, p1_qx_in, p1_qy_in;
   logic signed [DW-1:0] p1_rx_ff, p1_ry_ff, p1_sx_ff, p1_sy_ff, p1_qx_ff, p1_qy_ff;
   logic signed [W-1:0]  p1_ax_ff, p1_ay_ff;

   assign p1_rx_in = {req_bus.query_end_x[W-1], req_bus.query_end_x}
                   - {req_bus.query_start_x[W-1], req_bus.query_start_x};
   assign p1_ry_in = {req_bus.query_end_y[W-1], req_bus.query_end_y}
                   - {req_bus.query_start_y[W-1], req_bus.query_start_y};
   assign p1_sx_in = {end_x_ff[W-1], end_x_ff} - {start_x_ff[W-1], start_x_ff};
   assign p1_sy_in = {end_y_ff[W-1], end_y_ff} - {start_y_ff[W-1], start_y_ff};
   assign p1_qx_in = {start_x_ff[W-1], start_x_ff}
                   - {req_bus.query_start_x[W-1], req_bus.query_start_x};
   assign p1_qy_in = {start_y_ff[W-1], start_y_ff}
                   - {req_bus.query_start_y[W-1], req_bus.query_start_y};

   always_ff @(posedge clock) begin
      if (rdy1) begin
         p1_rx_ff <= p1_rx_in;
         p1_ry_ff <= p1_ry_in;
         p1_sx_ff <= p1_sx_in;
         p1_sy_ff <= p1_sy_in;
         p1_qx_ff <= p1_qx_in;
         p1_qy_ff <= p1_qy_in;
         p1_ax_ff <= req_bus.query_start_x;
         p1_ay_ff <= req_bus.query_start_y;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: six partial products, |r| per axis
   // ---------------------------------------------------------------------
   logic signed [PW-1:0] p2_rxsy_in, p2_rysx_in, p2_qxsy_in, p2_qysx_in, p2_qxry_in, p2_qyrx_in;
   logic signed [PW-1:0] p2_rxsy_ff, p2_rysx_ff, p2_qxsy_ff, p2_qysx_ff, p2_qxry_ff, p2_qyrx_ff;
   logic [DW-1:0]        p2_rx_neg, p2_ry_neg;
   logic [W-1:0]         p2_mx_ff, p2_my_ff;
   logic                 p2_negx_ff, p2_negy_ff;
   logic signed [W-1:0]  p2_ax_ff, p2_ay_ff;

   assign p2_rxsy_in = p1_rx_ff * p1_sy_ff;
   assign p2_rysx_in = p1_ry_ff * p1_sx_ff;
   assign p2_qxsy_in = p1_qx_ff * p1_sy_ff;
   assign p2_qysx_in = p1_qy_ff * p1_sx_ff;
   assign p2_qxry_in = p1_qx_ff * p1_ry_ff;
   assign p2_qyrx_in = p1_qy_ff * p1_rx_ff;
   assign p2_rx_neg  = -p1_rx_ff;
   assign p2_ry_neg  = -p1_ry_ff;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         p2_rxsy_ff <= p2_rxsy_in;
         p2_rysx_ff <= p2_rysx_in;
         p2_qxsy_ff <= p2_qxsy_in;
         p2_qysx_ff <= p2_qysx_in;
         p2_qxry_ff <= p2_qxry_in;
         p2_qyrx_ff <= p2_qyrx_in;
         p2_negx_ff <= p1_rx_ff[DW-1];
         p2_negy_ff <= p1_ry_ff[DW-1];
         p2_mx_ff   <= p1_rx_ff[DW-1] ? p2_rx_neg[W-1:0] : p1_rx_ff[W-1:0];
         p2_my_ff   <= p1_ry_ff[DW-1] ? p2_ry_neg[W-1:0] : p1_ry_ff[W-1:0];
         p2_ax_ff   <= p1_ax_ff;
         p2_ay_ff   <= p1_ay_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: N = r x s, Sn = q x s, Tn = q x r
   // ---------------------------------------------------------------------
   logic signed [PW-1:0] p3_n_ff, p3_sn_ff, p3_tn_ff;
   logic [W-1:0]         p3_mx_ff, p3_my_ff;
   logic                 p3_negx_ff, p3_negy_ff;
   logic signed [W-1:0]  p3_ax_ff, p3_ay_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         p3_n_ff    <= p2_rxsy_ff - p2_rysx_ff;
         p3_sn_ff   <= p2_qxsy_ff - p2_qysx_ff;
         p3_tn_ff   <= p2_qxry_ff - p2_qyrx_ff;
         p3_mx_ff   <= p2_mx_ff;
         p3_my_ff   <= p2_my_ff;
         p3_negx_ff <= p2_negx_ff;
         p3_negy_ff <= p2_negy_ff;
         p3_ax_ff   <= p2_ax_ff;
         p3_ay_ff   <= p2_ay_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: magnitudes, signs and zero flags
   // ---------------------------------------------------------------------
   logic [PW-1:0]       p4_n_neg, p4_sn_neg, p4_tn_neg;
   logic [MW-1:0]       p4_an_ff, p4_as_ff, p4_at_ff;
   logic                p4_sgn_n_ff, p4_sgn_s_ff, p4_sgn_t_ff;
   logic                p4_nz_n_ff, p4_nz_s_ff, p4_nz_t_ff;
   logic [W-1:0]        p4_mx_ff, p4_my_ff;
   logic                p4_negx_ff, p4_negy_ff;
   logic signed [W-1:0] p4_ax_ff, p4_ay_ff;

   assign p4_n_neg  = -p3_n_ff;
   assign p4_sn_neg = -p3_sn_ff;
   assign p4_tn_neg = -p3_tn_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         p4_an_ff    <= p3_n_ff[PW-1]  ? p4_n_neg[MW-1:0]  : p3_n_ff[MW-1:0];
         p4_as_ff    <= p3_sn_ff[PW-1] ? p4_sn_neg[MW-1:0] : p3_sn_ff[MW-1:0];
         p4_at_ff    <= p3_tn_ff[PW-1] ? p4_tn_neg[MW-1:0] : p3_tn_ff[MW-1:0];
         p4_sgn_n_ff <= p3_n_ff[PW-1];
         p4_sgn_s_ff <= p3_sn_ff[PW-1];
         p4_sgn_t_ff <= p3_tn_ff[PW-1];
         p4_nz_n_ff  <= |p3_n_ff;
         p4_nz_s_ff  <= |p3_sn_ff;
         p4_nz_t_ff  <= |p3_tn_ff;
         p4_mx_ff    <= p3_mx_ff;
         p4_my_ff    <= p3_my_ff;
         p4_negx_ff  <= p3_negx_ff;
         p4_negy_ff  <= p3_negy_ff;
         p4_ax_ff    <= p3_ax_ff;
         p4_ay_ff    <= p3_ay_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: strict inside test on both ratios
   // ---------------------------------------------------------------------
   logic                     p5_hit_in;
   sipt_pkg::sipt_flags_type p5_flags_ff;
   logic [MW-1:0]            p5_num_ff, p5_den_ff;
   logic [MQ-1:0]            p5_mx_ff, p5_my_ff;
   logic signed [W-1:0]      p5_ax_ff, p5_ay_ff;

   assign p5_hit_in = p4_nz_n_ff
                   && p4_nz_s_ff && (p4_sgn_s_ff == p4_sgn_n_ff) && (p4_as_ff < p4_an_ff)
                   && p4_nz_t_ff && (p4_sgn_t_ff == p4_sgn_n_ff) && (p4_at_ff < p4_an_ff);

   always_ff @(posedge clock) begin
      if (rdy5) begin
         p5_flags_ff.hit   <= p5_hit_in;
         p5_flags_ff.neg_x <= p4_negx_ff;
         p5_flags_ff.neg_y <= p4_negy_ff;
         p5_num_ff         <= p5_hit_in ? p4_as_ff : '0;
         p5_den_ff         <= p4_an_ff;
         p5_mx_ff          <= MQ'(p4_mx_ff);
         p5_my_ff          <= MQ'(p4_my_ff);
         p5_ax_ff          <= p4_ax_ff;
         p5_ay_ff          <= p4_ay_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Divider: |Sn|*|rx|/|N|, |Sn|*|ry|/|N|, |Sn|*2^F/|N|
   // ---------------------------------------------------------------------
   sipt_pkg::sipt_flags_type div_flags;
   logic signed [W-1:0]      div_ax, div_ay;
   logic [MQ-1:0]            div_qx, div_qy, div_qf;

   sipt_mdiv #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_mdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p5_v_ff),
      .in_ready  (div_in_ready),
      .in_flags  (p5_flags_ff),
      .in_ax     (p5_ax_ff),
      .in_ay     (p5_ay_ff),
      .in_num    (p5_num_ff),
      .in_den    (p5_den_ff),
      .in_mul_x  (p5_mx_ff),
      .in_mul_y  (p5_my_ff),
      .out_valid (div_out_valid),
      .out_ready (rdy_out),
      .out_flags (div_flags),
      .out_ax    (div_ax),
      .out_ay    (div_ay),
      .out_quo_x (div_qx),
      .out_quo_y (div_qy),
      .out_quo_f (div_qf)
   );

   // ---------------------------------------------------------------------
   // Output register: point A +/- offset, miss forces the fixed reply
   // ---------------------------------------------------------------------
   logic [W-1:0]         out_px_in, out_py_in;
   logic                 out_hit_ff;
   logic signed [W-1:0]  out_x_ff, out_y_ff;
   logic [FRAC_BITS:0]   out_frac_ff;

   assign out_px_in = div_flags.neg_x ? (div_ax - div_qx[W-1:0]) : (div_ax + div_qx[W-1:0]);
   assign out_py_in = div_flags.neg_y ? (div_ay - div_qy[W-1:0]) : (div_ay + div_qy[W-1:0]);

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         out_hit_ff  <= div_flags.hit;
         out_x_ff    <= div_flags.hit ? out_px_in : '0;
         out_y_ff    <= div_flags.hit ? out_py_in : '0;
         out_frac_ff <= div_flags.hit ? {1'b0, div_qf[FRAC_BITS-1:0]}
                                      : {1'b1, {FRAC_BITS{1'b0}}};
      end
   end

   assign rsp_bus.valid    = out_v_ff;
   assign rsp_bus.hit      = out_hit_ff;
   assign rsp_bus.hit_x    = out_x_ff;
   assign rsp_bus.hit_y    = out_y_ff;
   assign rsp_bus.fraction = out_frac_ff;

endmodule
